// ===== hdl/rtka_pkg.sv =====
// Shared types, constants and field widths for the rapid-trigger key actuation block.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package rtka_pkg;

    localparam int KEY_COUNT = 64;
    localparam int KEY_W     = 6;
    localparam int TRAVEL_W  = 12;
    localparam int MODE_W    = 2;
    localparam int PHASE_W   = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 12;

    localparam logic [MODE_W-1:0] MODE_FIXED = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RAPID = 2'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTUATION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_SENS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_SENS   = 3'd4;

    typedef logic [KEY_W-1:0]    key_num_t;
    typedef logic [TRAVEL_W-1:0] travel_t;

    typedef enum logic [PHASE_W-1:0] {
        PH_REST = 2'd0,
        PH_DOWN = 2'd1,
        PH_UP   = 2'd2
    } phase_t;

    typedef struct packed {
        phase_t  phase;
        travel_t peak;
        logic    down;
    } key_entry_t;

    localparam key_entry_t KEY_STATE_RESET = '{phase: PH_REST, peak: '0, down: 1'b0};

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        travel_t           actuation;
        travel_t           reset_dist;
        travel_t           down_sens;
        travel_t           up_sens;
    } cfg_t;

    typedef struct packed {
        logic   is_pressed;
        logic   new_press;
        phase_t phase;
    } key_result_t;

endpackage

`default_nettype wire

// ===== hdl/rtka_cfg_regs.sv =====
// Configuration register file: mode, actuation, reset and sensitivity settings.
// Depends on rtka_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtka_cfg_regs (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire [rtka_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [rtka_pkg::CFG_DAT_W-1:0]     cfg_data,
    output rtka_pkg::cfg_t                    cfg
);
    import rtka_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_MODE:      cfg_next.mode       = cfg_data[MODE_W-1:0];
                CFG_ACTUATION: cfg_next.actuation  = cfg_data[TRAVEL_W-1:0];
                CFG_RESET:     cfg_next.reset_dist = cfg_data[TRAVEL_W-1:0];
                CFG_DOWN_SENS: cfg_next.down_sens  = cfg_data[TRAVEL_W-1:0];
                CFG_UP_SENS:   cfg_next.up_sens    = cfg_data[TRAVEL_W-1:0];
                default:       cfg_next            = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/rtka_key_mem.sv =====
// Per-key state memory with registered read and per-entry valid bits.
// Depends on rtka_pkg; an entry never written reads as the reset state.
`timescale 1ns / 1ps
`default_nettype none

module rtka_key_mem (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          rd_en,
    input  wire [rtka_pkg::KEY_W-1:0]    rd_addr,
    output rtka_pkg::key_entry_t         rd_data,
    input  wire                          wr_en,
    input  wire [rtka_pkg::KEY_W-1:0]    wr_addr,
    input  rtka_pkg::key_entry_t         wr_data
);
    import rtka_pkg::*;

    key_entry_t             mem [KEY_COUNT];
    logic [KEY_COUNT-1:0]   valid_reg;
    key_entry_t             rd_data_reg;

    assign rd_data = rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : KEY_STATE_RESET;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/rtka_key_update.sv =====
// Next-state logic for one key sample: fixed actuation and rapid-trigger phase machine.
// Depends on rtka_pkg; purely combinational.
`timescale 1ns / 1ps
`default_nettype none

module rtka_key_update (
    input  rtka_pkg::cfg_t                  cfg,
    input  wire [rtka_pkg::KEY_W-1:0]       key_number,
    input  wire [rtka_pkg::TRAVEL_W-1:0]    travel,
    input  rtka_pkg::key_entry_t            cur,
    output rtka_pkg::key_entry_t            nxt,
    output rtka_pkg::key_result_t           result,
    output logic                            in_range
);
    import rtka_pkg::*;

    logic [TRAVEL_W:0] t_plus_up;
    logic [TRAVEL_W:0] pk_plus_down;
    logic              at_reset;

    assign in_range     = (int'(key_number) < KEY_COUNT);
    assign t_plus_up    = {1'b0, travel} + {1'b0, cfg.up_sens};
    assign pk_plus_down = {1'b0, cur.peak} + {1'b0, cfg.down_sens};
    assign at_reset     = (travel <= cfg.reset_dist);

    always_comb begin
        nxt = cur;
        if (cfg.mode == MODE_FIXED) begin
            nxt.down = (travel >= cfg.actuation);
        end else if (cfg.mode == MODE_RAPID) begin
            case (cur.phase)
                PH_REST: begin
                    if (travel > cfg.actuation) begin
                        nxt = '{phase: PH_DOWN, peak: travel, down: 1'b1};
                    end
                end
                PH_DOWN: begin
                    if (at_reset) begin
                        nxt = '{phase: PH_REST, peak: travel, down: 1'b0};
                    end else if (t_plus_up < {1'b0, cur.peak}) begin
                        nxt = '{phase: PH_UP, peak: travel, down: 1'b0};
                    end else if (travel > cur.peak) begin
                        nxt.peak = travel;
                    end
                end
                PH_UP: begin
                    if (at_reset) begin
                        nxt = '{phase: PH_REST, peak: travel, down: 1'b0};
                    end else if (pk_plus_down < {1'b0, travel}) begin
                        nxt = '{phase: PH_DOWN, peak: travel, down: 1'b1};
                    end else if (travel < cur.peak) begin
                        nxt.peak = travel;
                    end
                end
                default: nxt = cur;
            endcase
        end
    end

    always_comb begin
        if (in_range) begin
            result.is_pressed = nxt.down;
            result.new_press  = !cur.down && nxt.down;
            result.phase      = nxt.phase;
        end else begin
            result = '{is_pressed: 1'b0, new_press: 1'b0, phase: PH_REST};
        end
    end

endmodule

`default_nettype wire

// ===== hdl/rapid_trigger_key_actuation.sv =====
// Rapid-trigger key actuation: one result per key travel sample, one sample per clock
// while the result output is not stalled. A sample is taken into the input stage while
// its key state is read from a state memory with one read port, one write port and
// registered read; the result register follows the input stage. The next sample is
// accepted in the same cycle the previous one is written back, and a one-entry forward
// of the last write-back covers a repeated key. No clearing pass follows reset: per-key
// valid bits return rest state.
// Depends on rtka_pkg, rtka_cfg_regs, rtka_key_mem and rtka_key_update.
`timescale 1ns / 1ps
`default_nettype none

module rapid_trigger_key_actuation (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire [rtka_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [rtka_pkg::CFG_DAT_W-1:0]    cfg_data,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire [rtka_pkg::KEY_W-1:0]        s_key_number,
    input  wire [rtka_pkg::TRAVEL_W-1:0]     s_travel,
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic [rtka_pkg::KEY_W-1:0]       m_key_out,
    output logic                             m_is_pressed,
    output logic                             m_new_press,
    output logic [rtka_pkg::PHASE_W-1:0]     m_phase_out
);
    import rtka_pkg::*;

    cfg_t        cfg;
    logic        s_accept;
    logic        s1_adv;

    logic        s1_valid_reg;
    key_num_t    s1_key_reg;
    travel_t     s1_travel_reg;

    logic        last_valid_reg;
    key_num_t    last_key_reg;
    key_entry_t  last_state_reg;

    logic        m_valid_reg;
    key_num_t    m_key_reg;
    key_result_t m_result_reg;

    key_entry_t  rd_state;
    key_entry_t  cur_state;
    key_entry_t  nxt_state;
    key_result_t result;
    logic        in_range;
    logic        wr_en;

    rtka_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rtka_key_mem u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_accept),
        .rd_addr (s_key_number),
        .rd_data (rd_state),
        .wr_en   (wr_en),
        .wr_addr (s1_key_reg),
        .wr_data (nxt_state)
    );

    rtka_key_update u_update (
        .cfg        (cfg),
        .key_number (s1_key_reg),
        .travel     (s1_travel_reg),
        .cur        (cur_state),
        .nxt        (nxt_state),
        .result     (result),
        .in_range   (in_range)
    );

    assign s1_adv   = !m_valid_reg || m_ready;
    assign s_ready  = !s1_valid_reg || s1_adv;
    assign s_accept = s_valid && s_ready;
    assign wr_en    = s1_valid_reg && s1_adv && in_range;

    // forward the most recent write-back of the same key
    assign cur_state = (last_valid_reg && (last_key_reg == s1_key_reg)) ? last_state_reg
                                                                        : rd_state;

    assign m_valid      = m_valid_reg;
    assign m_key_out    = m_key_reg;
    assign m_is_pressed = m_result_reg.is_pressed;
    assign m_new_press  = m_result_reg.new_press;
    assign m_phase_out  = m_result_reg.phase;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg   <= 1'b0;
            last_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (s_ready) begin
                s1_valid_reg <= s_valid;
            end
            if (wr_en) begin
                last_valid_reg <= 1'b1;
            end
            if (s1_adv) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_key_reg    <= s_key_number;
            s1_travel_reg <= s_travel;
        end
        if (wr_en) begin
            last_key_reg   <= s1_key_reg;
            last_state_reg <= nxt_state;
        end
        if (s1_adv && s1_valid_reg) begin
            m_key_reg    <= s1_key_reg;
            m_result_reg <= result;
        end
    end

endmodule

`default_nettype wire

// ===== sim/tb_rapid_trigger_key_actuation.sv =====
// Testbench for rapid_trigger_key_actuation: directed and random key travel samples, checked
// against a per-key behavioral predictor of the fixed-actuation and rapid-trigger modes.
// Depends on rtka_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_rapid_trigger_key_actuation;
    import rtka_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_PRINTS     = 40;

    typedef struct packed {
        key_num_t key;
        logic     pressed;
        logic     fresh;
        phase_t   phase;
    } key_report_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    key_num_t             s_key_number;
    travel_t              s_travel;
    logic                 m_valid;
    logic                 m_ready;
    key_num_t             m_key_out;
    logic                 m_is_pressed;
    logic                 m_new_press;
    logic [PHASE_W-1:0]   m_phase_out;

    // predictor state and settings
    logic [MODE_W-1:0] set_mode;
    travel_t           set_actuation;
    travel_t           set_reset;
    travel_t           set_down_sens;
    travel_t           set_up_sens;
    phase_t            key_ph   [KEY_COUNT];
    travel_t           key_peak [KEY_COUNT];
    logic              key_dn   [KEY_COUNT];
    int                walk_pos [KEY_COUNT];

    key_report_t pending_reports[$];
    int          mismatch_count;
    int          idle_cycles;
    int          tx_idle_mode;
    int          rx_idle_mode;

    rapid_trigger_key_actuation DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_key_number (s_key_number),
        .s_travel     (s_travel),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_key_out    (m_key_out),
        .m_is_pressed (m_is_pressed),
        .m_new_press  (m_new_press),
        .m_phase_out  (m_phase_out)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    function automatic int draw_gap(int idle_mode);
        case (idle_mode)
            0: return 0;
            1: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
            default: return $urandom_range(0, 16);
        endcase
    endfunction

    function automatic key_report_t predict_key(key_num_t key, travel_t tr);
        key_report_t r;
        logic        was;
        int          t;
        int          pk;
        was = key_dn[key];
        t   = tr;
        pk  = key_peak[key];
        if (set_mode == MODE_FIXED) begin
            key_dn[key] = (tr >= set_actuation);
        end else if (set_mode == MODE_RAPID) begin
            case (key_ph[key])
                PH_REST: begin
                    if (tr > set_actuation) begin
                        key_ph[key]   = PH_DOWN;
                        key_peak[key] = tr;
                        key_dn[key]   = 1'b1;
                    end
                end
                PH_DOWN: begin
                    if (tr <= set_reset) begin
                        key_ph[key]   = PH_REST;
                        key_peak[key] = tr;
                        key_dn[key]   = 1'b0;
                    end else if (t + int'(set_up_sens) < pk) begin
                        key_ph[key]   = PH_UP;
                        key_peak[key] = tr;
                        key_dn[key]   = 1'b0;
                    end else if (t > pk) begin
                        key_peak[key] = tr;
                    end
                end
                PH_UP: begin
                    if (tr <= set_reset) begin
                        key_ph[key]   = PH_REST;
                        key_peak[key] = tr;
                        key_dn[key]   = 1'b0;
                    end else if (pk + int'(set_down_sens) < t) begin
                        key_ph[key]   = PH_DOWN;
                        key_peak[key] = tr;
                        key_dn[key]   = 1'b1;
                    end else if (t < pk) begin
                        key_peak[key] = tr;
                    end
                end
                default: ;
            endcase
        end
        r.key     = key;
        r.pressed = key_dn[key];
        r.fresh   = !was && key_dn[key];
        r.phase   = key_ph[key];
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        if (mismatch_count < MAX_PRINTS)
            $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_sample(key_num_t key, travel_t tr);
        int gap;
        gap = draw_gap(tx_idle_mode);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_key_number <= key;
        s_travel     <= tr;
        do @(posedge aclk); while (!s_ready);
        pending_reports.push_back(predict_key(key, tr));
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_MODE:      set_mode      = data[MODE_W-1:0];
            CFG_ACTUATION: set_actuation = data;
            CFG_RESET:     set_reset     = data;
            CFG_DOWN_SENS: set_down_sens = data;
            CFG_UP_SENS:   set_up_sens   = data;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_mode(logic [MODE_W-1:0] m);
        logic [CFG_DAT_W-1:0] data;
        data = CFG_DAT_W'($urandom_range(0, 4095));
        data[MODE_W-1:0] = m;
        write_setting(CFG_MODE, data);
    endtask

    task automatic write_rapid_set(int act, int rst, int dn, int up);
        write_mode(MODE_RAPID);
        write_setting(CFG_ACTUATION, travel_t'(act));
        write_setting(CFG_RESET, travel_t'(rst));
        write_setting(CFG_DOWN_SENS, travel_t'(dn));
        write_setting(CFG_UP_SENS, travel_t'(up));
    endtask

    task automatic test_reset_state();
        tx_idle_mode = 0;
        send_sample(key_num_t'(0), travel_t'(0));
        send_sample(key_num_t'(KEY_COUNT - 1), travel_t'(4095));
        wait_idle();
    endtask

    task automatic test_fixed_actuation();
        write_mode(MODE_FIXED);
        write_setting(CFG_ACTUATION, travel_t'(2048));
        send_sample(key_num_t'(1), travel_t'(2047));
        send_sample(key_num_t'(1), travel_t'(2048));
        send_sample(key_num_t'(1), travel_t'(4095));
        send_sample(key_num_t'(1), travel_t'(0));
        wait_idle();
        write_setting(CFG_ACTUATION, travel_t'(4095));
        send_sample(key_num_t'(2), travel_t'(4094));
        send_sample(key_num_t'(2), travel_t'(4095));
        wait_idle();
    endtask

    task automatic test_rapid_trigger();
        write_rapid_set(1000, 200, 100, 100);
        // exercise rest, down, up, re-press and both returns to rest on one key
        send_sample(key_num_t'(5), travel_t'(1000));
        send_sample(key_num_t'(5), travel_t'(1001));
        send_sample(key_num_t'(5), travel_t'(1500));
        send_sample(key_num_t'(5), travel_t'(1450));
        send_sample(key_num_t'(5), travel_t'(1399));
        send_sample(key_num_t'(5), travel_t'(1450));
        send_sample(key_num_t'(5), travel_t'(1350));
        send_sample(key_num_t'(5), travel_t'(1451));
        send_sample(key_num_t'(5), travel_t'(1300));
        send_sample(key_num_t'(5), travel_t'(150));
        send_sample(key_num_t'(5), travel_t'(4095));
        send_sample(key_num_t'(5), travel_t'(100));
        wait_idle();
    endtask

    task automatic test_hold_modes();
        write_mode(2'd2);
        send_sample(key_num_t'(5), travel_t'(4095));
        send_sample(key_num_t'(0), travel_t'(0));
        wait_idle();
        write_mode(2'd3);
        send_sample(key_num_t'(0), travel_t'(4095));
        wait_idle();
    endtask

    task automatic test_rapid_walk(int phases, int count);
        int       base;
        int       pos;
        key_num_t key;
        for (int p = 0; p < phases; p++) begin
            case (p)
                0: write_rapid_set(0, 0, 0, 0);
                1: write_rapid_set(4095, 0, 0, 0);
                2: write_rapid_set(4094, 4095, 4095, 4095);
                3: write_rapid_set(0, 0, 4095, 0);
                4: write_rapid_set(0, 0, 0, 4095);
                default: begin
                    write_rapid_set($urandom_range(200, 3000), $urandom_range(0, 800),
                                    $urandom_range(0, 400), $urandom_range(0, 400));
                    write_setting(CFG_UP_SENS + CFG_IDX_W'($urandom_range(1, 3)),
                                  CFG_DAT_W'($urandom_range(0, 4095)));
                end
            endcase
            tx_idle_mode = $urandom_range(0, 2);
            base = $urandom_range(0, KEY_COUNT - 4);
            for (int i = 0; i < count; i++) begin
                if ($urandom_range(0, 3) == 0)
                    key = key_num_t'($urandom_range(0, KEY_COUNT - 1));
                else
                    key = key_num_t'(base + $urandom_range(0, 3));
                if ($urandom_range(0, 9) == 0)
                    pos = $urandom_range(0, 4095);
                else
                    pos = walk_pos[key] + $urandom_range(0, 600) - 300;
                if (pos < 0) pos = 0;
                if (pos > 4095) pos = 4095;
                walk_pos[key] = pos;
                send_sample(key, travel_t'(pos));
            end
            wait_idle();
        end
    endtask

    task automatic test_random_modes(int phases, int count);
        for (int p = 0; p < phases; p++) begin
            write_mode(MODE_W'(p));
            write_setting(CFG_ACTUATION, CFG_DAT_W'($urandom_range(0, 4095)));
            write_setting(CFG_RESET, CFG_DAT_W'($urandom_range(0, 4095)));
            write_setting(CFG_DOWN_SENS, CFG_DAT_W'($urandom_range(0, 4095)));
            write_setting(CFG_UP_SENS, CFG_DAT_W'($urandom_range(0, 4095)));
            write_setting(CFG_UP_SENS + CFG_IDX_W'($urandom_range(1, 3)),
                          CFG_DAT_W'($urandom_range(0, 4095)));
            tx_idle_mode = $urandom_range(0, 2);
            for (int i = 0; i < count; i++)
                send_sample(key_num_t'($urandom_range(0, KEY_COUNT - 1)),
                            travel_t'($urandom_range(0, 4095)));
            wait_idle();
        end
    endtask

    // result side: random stalls, check each transaction against the oldest prediction
    initial begin
        key_report_t want;
        int          stall;
        int          seen;
        seen = 0;
        rx_idle_mode = 2;
        m_ready = 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (seen % 50 == 0) rx_idle_mode = $urandom_range(0, 2);
            stall = draw_gap(rx_idle_mode);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            seen++;
            if (pending_reports.size() == 0) begin
                report_mismatch("result with nothing pending, key", m_key_out, -1);
            end else begin
                want = pending_reports.pop_front();
                if (m_key_out !== want.key)
                    report_mismatch("key_out", m_key_out, want.key);
                if (m_is_pressed !== want.pressed)
                    report_mismatch("is_pressed", m_is_pressed, want.pressed);
                if (m_new_press !== want.fresh)
                    report_mismatch("new_press", m_new_press, want.fresh);
                if (m_phase_out !== want.phase)
                    report_mismatch("phase_out", m_phase_out, want.phase);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        s_valid        = 1'b0;
        s_key_number   = '0;
        s_travel       = '0;
        idle_cycles    = 0;
        mismatch_count = 0;
        tx_idle_mode   = 0;
        set_mode       = MODE_FIXED;
        set_actuation  = '0;
        set_reset      = '0;
        set_down_sens  = '0;
        set_up_sens    = '0;
        for (int k = 0; k < KEY_COUNT; k++) begin
            key_ph[k]   = PH_REST;
            key_peak[k] = '0;
            key_dn[k]   = 1'b0;
            walk_pos[k] = 0;
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_fixed_actuation();
        test_rapid_trigger();
        test_hold_modes();
        test_rapid_walk(8, 90);
        test_random_modes(4, 80);

        wait_idle();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && pending_reports.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
